### rtl/arp_pkg.sv
package arp_pkg;

    // operation class picked from the relocation type
    typedef enum logic [2:0] {
        OP_NONE,
        OP_UNSUP,
        OP_D64,
        OP_D32,
        OP_D16,
        OP_MOVW,
        OP_IMM
    } op_t;

    // how the relocation value is formed from s+a and the place
    typedef enum logic [1:0] {
        KIND_ABS,
        KIND_PREL,
        KIND_PAGE
    } kind_t;

    // immediate field layouts with their scaling
    typedef enum logic [3:0] {
        IMM_LO19,
        IMM_ADR,
        IMM_ADRP,
        IMM_LO12_S0,
        IMM_LO12_S1,
        IMM_LO12_S2,
        IMM_LO12_S3,
        IMM_LO12_S4,
        IMM_TBZ14,
        IMM_B26
    } immk_t;

    typedef struct packed {
        op_t        op;
        kind_t      kind;
        logic       data_signed;
        logic [1:0] group;
        logic       mov_signed;
        immk_t      immk;
        logic       chk;
    } dec_t;

    localparam int unsigned PAGE_SHIFT   = 12;
    localparam logic [31:0] MOV_OPC_MASK = 32'h6000_0000;
    localparam logic [31:0] MOV_OPC_MOVZ = 32'h4000_0000;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_16   = 2'd1;
    localparam logic [1:0] SIZE_32   = 2'd2;
    localparam logic [1:0] SIZE_64   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [31:0] R_NONE             = 32'd0;
    localparam logic [31:0] R_ABS64            = 32'd257;
    localparam logic [31:0] R_ABS32            = 32'd258;
    localparam logic [31:0] R_ABS16            = 32'd259;
    localparam logic [31:0] R_PREL64           = 32'd260;
    localparam logic [31:0] R_PREL32           = 32'd261;
    localparam logic [31:0] R_PREL16           = 32'd262;
    localparam logic [31:0] R_MOVW_UABS_G0     = 32'd263;
    localparam logic [31:0] R_MOVW_UABS_G0_NC  = 32'd264;
    localparam logic [31:0] R_MOVW_UABS_G1     = 32'd265;
    localparam logic [31:0] R_MOVW_UABS_G1_NC  = 32'd266;
    localparam logic [31:0] R_MOVW_UABS_G2     = 32'd267;
    localparam logic [31:0] R_MOVW_UABS_G2_NC  = 32'd268;
    localparam logic [31:0] R_MOVW_UABS_G3     = 32'd269;
    localparam logic [31:0] R_MOVW_SABS_G0     = 32'd270;
    localparam logic [31:0] R_MOVW_SABS_G1     = 32'd271;
    localparam logic [31:0] R_MOVW_SABS_G2     = 32'd272;
    localparam logic [31:0] R_LD_PREL_LO19     = 32'd273;
    localparam logic [31:0] R_ADR_PREL_LO21    = 32'd274;
    localparam logic [31:0] R_ADR_PREL_PG_HI21 = 32'd275;
    localparam logic [31:0] R_ADR_PG_HI21_NC   = 32'd276;
    localparam logic [31:0] R_ADD_ABS_LO12_NC  = 32'd277;
    localparam logic [31:0] R_LDST8_LO12_NC    = 32'd278;
    localparam logic [31:0] R_TSTBR14          = 32'd279;
    localparam logic [31:0] R_CONDBR19         = 32'd280;
    localparam logic [31:0] R_JUMP26           = 32'd282;
    localparam logic [31:0] R_CALL26           = 32'd283;
    localparam logic [31:0] R_LDST16_LO12_NC   = 32'd284;
    localparam logic [31:0] R_LDST32_LO12_NC   = 32'd285;
    localparam logic [31:0] R_LDST64_LO12_NC   = 32'd286;
    localparam logic [31:0] R_MOVW_PREL_G0     = 32'd287;
    localparam logic [31:0] R_MOVW_PREL_G0_NC  = 32'd288;
    localparam logic [31:0] R_MOVW_PREL_G1     = 32'd289;
    localparam logic [31:0] R_MOVW_PREL_G1_NC  = 32'd290;
    localparam logic [31:0] R_MOVW_PREL_G2     = 32'd291;
    localparam logic [31:0] R_MOVW_PREL_G2_NC  = 32'd292;
    localparam logic [31:0] R_MOVW_PREL_G3     = 32'd293;
    localparam logic [31:0] R_LDST128_LO12_NC  = 32'd299;

endpackage

### rtl/aarch64_relocation_patcher_core.sv
// aarch64 elf rela relocation patcher
//
// one relocation comes in per s_ transaction: type, place address, symbol
// value, addend and the old contents of the place. one result leaves per
// m_ transaction: the patched word, the write size and a status
// (ok, checked overflow, unsupported type)
//
// two register stages: the input register holds the type, place, old word
// and the sum symbol+addend; the result register holds the patched word.
// decode, the pc/page subtraction, field insert and range check sit
// between them
// a transaction accepted on s_ is held in the input register, then in the
// result register, which drives m_
// throughput: one relocation per cycle while m_tready stays high
// when the receiver stalls, the result holds and one more relocation
// waits in the input register before s_tready falls
// reset (aresetn low at a clock edge) empties both stages
module aarch64_relocation_patcher_core (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // action[31:0], place_address[95:32], symbol_value[159:96],
    // addend[223:160], old_word[287:224]
    input  logic [287:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // new_word[63:0], write_size[65:64], status[67:66], zero fill[71:68]
    output logic [71:0]  m_tdata
);

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [31:0] act_reg;
    logic [63:0] place_reg;
    logic [63:0] sa_reg;
    logic [63:0] old_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic [63:0] word_reg;
    logic [1:0]  size_reg;
    logic [1:0]  status_reg;

    logic        load_in;
    logic        advance;

    arp_pkg::dec_t dec;
    logic [63:0]   new_word;
    logic [1:0]    write_size;
    logic [1:0]    status;

    // result stage can take a new value when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
            in_valid_next  = 1'b0;
        end
        if (load_in) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // s+a is formed on the way in, modulo 2^64
    always_ff @(posedge aclk) begin
        if (load_in) begin
            act_reg   <= s_tdata[31:0];
            place_reg <= s_tdata[95:32];
            sa_reg    <= s_tdata[159:96] + s_tdata[223:160];
            old_reg   <= s_tdata[287:224];
        end
    end

    arp_decode u_decode (
        .action (act_reg),
        .dec    (dec)
    );

    arp_patch u_patch (
        .dec           (dec),
        .place_address (place_reg),
        .sym_add       (sa_reg),
        .old_word      (old_reg),
        .new_word      (new_word),
        .write_size    (write_size),
        .status        (status)
    );

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            word_reg   <= new_word;
            size_reg   <= write_size;
            status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, status_reg, size_reg, word_reg};

endmodule

### rtl/arp_decode.sv
module arp_decode (
    input  logic [31:0]  action,
    output arp_pkg::dec_t dec
);

    always_comb begin
        dec.op          = arp_pkg::OP_UNSUP;
        dec.kind        = arp_pkg::KIND_ABS;
        dec.data_signed = 1'b0;
        dec.group       = 2'd0;
        dec.mov_signed  = 1'b0;
        dec.immk        = arp_pkg::IMM_LO19;
        dec.chk         = 1'b1;
        case (action)
            arp_pkg::R_NONE: begin
                dec.op  = arp_pkg::OP_NONE;
                dec.chk = 1'b0;
            end
            arp_pkg::R_ABS64: begin
                dec.op  = arp_pkg::OP_D64;
                dec.chk = 1'b0;
            end
            arp_pkg::R_PREL64: begin
                dec.op   = arp_pkg::OP_D64;
                dec.kind = arp_pkg::KIND_PREL;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_ABS32: begin
                dec.op = arp_pkg::OP_D32;
            end
            arp_pkg::R_PREL32: begin
                dec.op          = arp_pkg::OP_D32;
                dec.kind        = arp_pkg::KIND_PREL;
                dec.data_signed = 1'b1;
            end
            arp_pkg::R_ABS16: begin
                dec.op = arp_pkg::OP_D16;
            end
            arp_pkg::R_PREL16: begin
                dec.op          = arp_pkg::OP_D16;
                dec.kind        = arp_pkg::KIND_PREL;
                dec.data_signed = 1'b1;
            end
            // unsigned absolute movw groups
            arp_pkg::R_MOVW_UABS_G0: begin
                dec.op = arp_pkg::OP_MOVW;
            end
            arp_pkg::R_MOVW_UABS_G0_NC: begin
                dec.op  = arp_pkg::OP_MOVW;
                dec.chk = 1'b0;
            end
            arp_pkg::R_MOVW_UABS_G1: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.group = 2'd1;
            end
            arp_pkg::R_MOVW_UABS_G1_NC: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.group = 2'd1;
                dec.chk   = 1'b0;
            end
            arp_pkg::R_MOVW_UABS_G2: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.group = 2'd2;
            end
            arp_pkg::R_MOVW_UABS_G2_NC: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.group = 2'd2;
                dec.chk   = 1'b0;
            end
            arp_pkg::R_MOVW_UABS_G3: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.group = 2'd3;
                dec.chk   = 1'b0;
            end
            // signed absolute movw groups
            arp_pkg::R_MOVW_SABS_G0: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.mov_signed = 1'b1;
            end
            arp_pkg::R_MOVW_SABS_G1: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.group      = 2'd1;
                dec.mov_signed = 1'b1;
            end
            arp_pkg::R_MOVW_SABS_G2: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.group      = 2'd2;
                dec.mov_signed = 1'b1;
            end
            // pc-relative movw groups
            arp_pkg::R_MOVW_PREL_G0: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.kind       = arp_pkg::KIND_PREL;
                dec.mov_signed = 1'b1;
            end
            arp_pkg::R_MOVW_PREL_G0_NC: begin
                dec.op   = arp_pkg::OP_MOVW;
                dec.kind = arp_pkg::KIND_PREL;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_MOVW_PREL_G1: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.kind       = arp_pkg::KIND_PREL;
                dec.group      = 2'd1;
                dec.mov_signed = 1'b1;
            end
            arp_pkg::R_MOVW_PREL_G1_NC: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.kind  = arp_pkg::KIND_PREL;
                dec.group = 2'd1;
                dec.chk   = 1'b0;
            end
            arp_pkg::R_MOVW_PREL_G2: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.kind       = arp_pkg::KIND_PREL;
                dec.group      = 2'd2;
                dec.mov_signed = 1'b1;
            end
            arp_pkg::R_MOVW_PREL_G2_NC: begin
                dec.op    = arp_pkg::OP_MOVW;
                dec.kind  = arp_pkg::KIND_PREL;
                dec.group = 2'd2;
                dec.chk   = 1'b0;
            end
            arp_pkg::R_MOVW_PREL_G3: begin
                dec.op         = arp_pkg::OP_MOVW;
                dec.kind       = arp_pkg::KIND_PREL;
                dec.group      = 2'd3;
                dec.mov_signed = 1'b1;
                dec.chk        = 1'b0;
            end
            arp_pkg::R_LD_PREL_LO19, arp_pkg::R_CONDBR19: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.kind = arp_pkg::KIND_PREL;
                dec.immk = arp_pkg::IMM_LO19;
            end
            arp_pkg::R_ADR_PREL_LO21: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.kind = arp_pkg::KIND_PREL;
                dec.immk = arp_pkg::IMM_ADR;
            end
            arp_pkg::R_ADR_PREL_PG_HI21: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.kind = arp_pkg::KIND_PAGE;
                dec.immk = arp_pkg::IMM_ADRP;
            end
            arp_pkg::R_ADR_PG_HI21_NC: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.kind = arp_pkg::KIND_PAGE;
                dec.immk = arp_pkg::IMM_ADRP;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_ADD_ABS_LO12_NC, arp_pkg::R_LDST8_LO12_NC: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.immk = arp_pkg::IMM_LO12_S0;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_LDST16_LO12_NC: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.immk = arp_pkg::IMM_LO12_S1;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_LDST32_LO12_NC: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.immk = arp_pkg::IMM_LO12_S2;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_LDST64_LO12_NC: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.immk = arp_pkg::IMM_LO12_S3;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_LDST128_LO12_NC: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.immk = arp_pkg::IMM_LO12_S4;
                dec.chk  = 1'b0;
            end
            arp_pkg::R_TSTBR14: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.kind = arp_pkg::KIND_PREL;
                dec.immk = arp_pkg::IMM_TBZ14;
            end
            arp_pkg::R_JUMP26, arp_pkg::R_CALL26: begin
                dec.op   = arp_pkg::OP_IMM;
                dec.kind = arp_pkg::KIND_PREL;
                dec.immk = arp_pkg::IMM_B26;
            end
            default: begin
                dec.op = arp_pkg::OP_UNSUP;
            end
        endcase
    end

endmodule

### rtl/arp_patch.sv
module arp_patch (
    input  arp_pkg::dec_t dec,
    input  logic [63:0]   place_address,
    input  logic [63:0]   sym_add,
    input  logic [63:0]   old_word,
    output logic [63:0]   new_word,
    output logic [1:0]    write_size,
    output logic [1:0]    status
);

    localparam int unsigned PS = arp_pkg::PAGE_SHIFT;

    logic [63:0]    d;
    logic [63-PS:0] page_diff;
    logic [63:0]    mov_v;
    logic [63:0]    mov_imm;
    logic [31:0]    insn;
    logic           ovf;

    assign page_diff = sym_add[63:PS] - place_address[63:PS];

    always_comb begin
        case (dec.kind)
            arp_pkg::KIND_ABS:  d = sym_add;
            arp_pkg::KIND_PREL: d = sym_add - place_address;
            arp_pkg::KIND_PAGE: d = {page_diff, {PS{1'b0}}};
            default:            d = sym_add;
        endcase
    end

    // movw: arithmetic shift by the group, then one's complement for negative signed values
    always_comb begin
        case (dec.group)
            2'd0:    mov_v = d;
            2'd1:    mov_v = {{16{d[63]}}, d[63:16]};
            2'd2:    mov_v = {{32{d[63]}}, d[63:32]};
            2'd3:    mov_v = {{48{d[63]}}, d[63:48]};
            default: mov_v = d;
        endcase
        mov_imm = (dec.mov_signed && d[63]) ? ~mov_v : mov_v;
    end

    always_comb begin
        insn       = old_word[31:0];
        ovf        = 1'b0;
        new_word   = old_word;
        write_size = arp_pkg::SIZE_32;
        case (dec.op)
            arp_pkg::OP_NONE, arp_pkg::OP_UNSUP: begin
                write_size = arp_pkg::SIZE_NONE;
            end
            arp_pkg::OP_D64: begin
                new_word   = d;
                write_size = arp_pkg::SIZE_64;
            end
            arp_pkg::OP_D32: begin
                new_word = {old_word[63:32], d[31:0]};
                ovf      = dec.data_signed ? !((&d[63:31]) || !(|d[63:31])) : (|d[63:32]);
            end
            arp_pkg::OP_D16: begin
                new_word   = {old_word[63:16], d[15:0]};
                write_size = arp_pkg::SIZE_16;
                ovf        = dec.data_signed ? !((&d[63:15]) || !(|d[63:15])) : (|d[63:16]);
            end
            arp_pkg::OP_MOVW: begin
                if (dec.mov_signed) begin
                    insn = insn & ~arp_pkg::MOV_OPC_MASK;
                    if (!d[63]) begin
                        insn = insn | arp_pkg::MOV_OPC_MOVZ;
                    end
                end
                insn     = {insn[31:21], mov_imm[15:0], insn[4:0]};
                ovf      = |mov_imm[63:16];
                new_word = {old_word[63:32], insn};
            end
            arp_pkg::OP_IMM: begin
                case (dec.immk)
                    arp_pkg::IMM_LO19: begin
                        insn = {insn[31:24], d[20:2], insn[4:0]};
                        ovf  = !((&d[63:20]) || !(|d[63:20]));
                    end
                    arp_pkg::IMM_ADR: begin
                        insn = {insn[31], d[1:0], insn[28:24], d[20:2], insn[4:0]};
                        ovf  = !((&d[63:20]) || !(|d[63:20]));
                    end
                    arp_pkg::IMM_ADRP: begin
                        insn = {insn[31], d[13:12], insn[28:24], d[32:14], insn[4:0]};
                        ovf  = !((&d[63:32]) || !(|d[63:32]));
                    end
                    arp_pkg::IMM_LO12_S0: insn = {insn[31:22], d[11:0], insn[9:0]};
                    arp_pkg::IMM_LO12_S1: insn = {insn[31:22], 1'b0, d[11:1], insn[9:0]};
                    arp_pkg::IMM_LO12_S2: insn = {insn[31:22], 2'b0, d[11:2], insn[9:0]};
                    arp_pkg::IMM_LO12_S3: insn = {insn[31:22], 3'b0, d[11:3], insn[9:0]};
                    arp_pkg::IMM_LO12_S4: insn = {insn[31:22], 4'b0, d[11:4], insn[9:0]};
                    arp_pkg::IMM_TBZ14: begin
                        insn = {insn[31:19], d[15:2], insn[4:0]};
                        ovf  = !((&d[63:15]) || !(|d[63:15]));
                    end
                    arp_pkg::IMM_B26: begin
                        insn = {insn[31:26], d[27:2]};
                        ovf  = !((&d[63:27]) || !(|d[63:27]));
                    end
                    default: insn = old_word[31:0];
                endcase
                new_word = {old_word[63:32], insn};
            end
            default: begin
                write_size = arp_pkg::SIZE_NONE;
            end
        endcase
    end

    always_comb begin
        if (dec.op == arp_pkg::OP_UNSUP) begin
            status = arp_pkg::ST_UNSUP;
        end else if (dec.chk && ovf) begin
            status = arp_pkg::ST_OVF;
        end else begin
            status = arp_pkg::ST_OK;
        end
    end

endmodule

### rtl/arp_checker.sv
module arp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // both stages empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:66] != 2'd3)
        else $error("undefined status code");

    // unsupported types never write, overflow always comes with a write
    a_status_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[67:66] != 2'd2 || m_tdata[65:64] == 2'd0)
                  && (m_tdata[67:66] != 2'd1 || m_tdata[65:64] != 2'd0))
        else $error("status and write size disagree");

    // input ready only drops when a result is stalled
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

bind aarch64_relocation_patcher_core arp_checker u_arp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb_aarch64_relocation_patcher_core.sv
`timescale 1ns / 100ps

module tb_aarch64_relocation_patcher_core;

    // cycles without any transaction before the run is called dead
    localparam int unsigned STALL_LIMIT = 5000;
    // random relocations per phase
    localparam int unsigned RANDOM_PER_PHASE = 182;
    // cycles to let pass after the last result (two register stages)
    localparam int unsigned DRAIN_CYCLES = 8;

    // one relocation as it enters the block
    typedef struct {
        logic [31:0]        action;
        logic [63:0]        place_address;
        logic [63:0]        symbol_value;
        logic signed [63:0] addend;
        logic [63:0]        old_word;
    } reloc_t;

    // one patch result as it leaves the block
    typedef struct {
        logic [63:0] new_word;
        logic [1:0]  write_size;
        logic [1:0]  status;
    } patch_t;

    // instruction immediate layouts
    typedef enum logic [2:0] {
        FLD_IMM12,
        FLD_IMM14,
        FLD_IMM19,
        FLD_IMM26,
        FLD_ADR
    } field_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // action, place_address, symbol_value, addend, old_word from bit 0 up
    logic [287:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // new_word, write_size, status, zero fill from bit 0 up
    logic [71:0]  m_tdata;

    // every supported type, drawn from for random relocations
    logic [31:0] known_types [0:36] = '{
        arp_pkg::R_ABS64, arp_pkg::R_ABS32, arp_pkg::R_ABS16,
        arp_pkg::R_PREL64, arp_pkg::R_PREL32, arp_pkg::R_PREL16,
        arp_pkg::R_MOVW_UABS_G0, arp_pkg::R_MOVW_UABS_G0_NC,
        arp_pkg::R_MOVW_UABS_G1, arp_pkg::R_MOVW_UABS_G1_NC,
        arp_pkg::R_MOVW_UABS_G2, arp_pkg::R_MOVW_UABS_G2_NC,
        arp_pkg::R_MOVW_UABS_G3,
        arp_pkg::R_MOVW_SABS_G0, arp_pkg::R_MOVW_SABS_G1, arp_pkg::R_MOVW_SABS_G2,
        arp_pkg::R_LD_PREL_LO19, arp_pkg::R_ADR_PREL_LO21,
        arp_pkg::R_ADR_PREL_PG_HI21, arp_pkg::R_ADR_PG_HI21_NC,
        arp_pkg::R_ADD_ABS_LO12_NC, arp_pkg::R_LDST8_LO12_NC,
        arp_pkg::R_TSTBR14, arp_pkg::R_CONDBR19,
        arp_pkg::R_JUMP26, arp_pkg::R_CALL26,
        arp_pkg::R_LDST16_LO12_NC, arp_pkg::R_LDST32_LO12_NC,
        arp_pkg::R_LDST64_LO12_NC,
        arp_pkg::R_MOVW_PREL_G0, arp_pkg::R_MOVW_PREL_G0_NC,
        arp_pkg::R_MOVW_PREL_G1, arp_pkg::R_MOVW_PREL_G1_NC,
        arp_pkg::R_MOVW_PREL_G2, arp_pkg::R_MOVW_PREL_G2_NC,
        arp_pkg::R_MOVW_PREL_G3,
        arp_pkg::R_LDST128_LO12_NC
    };

    reloc_t      pending_relocs[$];    // relocations not yet offered
    patch_t      expected_patches[$];  // predicted results, oldest first
    reloc_t      offered_reloc;        // relocation currently on s_
    int unsigned relocs_queued = 0;
    int unsigned relocs_taken  = 0;
    int unsigned mismatches    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles  = 0;

    aarch64_relocation_patcher_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // patch prediction
    // ---------------------------------------------------------------

    // sign-filling right shift
    function automatic logic [63:0] shift_arith(input logic [63:0] x, input int unsigned sh);
        return $signed(x) >>> sh;
    endfunction

    // relocation value from s+a and the place
    function automatic logic [63:0] reloc_value(input arp_pkg::kind_t kind,
                                                input logic [63:0] place,
                                                input logic [63:0] sa);
        case (kind)
            arp_pkg::KIND_PREL: return sa - place;
            arp_pkg::KIND_PAGE: return {sa[63:arp_pkg::PAGE_SHIFT], 12'h000} -
                                       {place[63:arp_pkg::PAGE_SHIFT], 12'h000};
            default:            return sa;
        endcase
    endfunction

    // scaled immediate into its instruction field, overflow if the
    // shifted value is not a sign extension of its low len bits
    function automatic logic [31:0] insert_imm(input logic [63:0] d, input int unsigned lsb,
                                               input int unsigned len, input field_t fld,
                                               input logic [31:0] insn, output logic ovf);
        logic [63:0] v;
        logic [63:0] mask;
        logic [63:0] hi;
        logic [63:0] hi_inc;
        logic [31:0] res;
        v      = shift_arith(d, lsb);
        mask   = (64'd1 << len) - 64'd1;
        hi     = shift_arith(v & ~(mask >> 1), len - 1);
        hi_inc = hi + 64'd1;
        ovf    = hi_inc >= 64'd2;
        v      = v & mask;
        res    = insn;
        case (fld)
            FLD_IMM12: res[21:10] = v[11:0];
            FLD_IMM14: res[18:5]  = v[13:0];
            FLD_IMM19: res[23:5]  = v[18:0];
            FLD_IMM26: res[25:0]  = v[25:0];
            default: begin
                // adr/adrp: immlo in 30:29, immhi in 23:5
                res[30:29] = v[1:0];
                res[23:5]  = v[20:2];
            end
        endcase
        return res;
    endfunction

    // movz/movk/movn 16-bit chunk, signed groups pick movz or movn
    function automatic logic [31:0] insert_movw(input logic [63:0] d, input int unsigned lsb,
                                                input logic sgn, input logic [31:0] insn,
                                                output logic ovf);
        logic [63:0] imm;
        logic [31:0] res;
        imm = shift_arith(d, lsb);
        res = insn;
        if (sgn) begin
            res = res & ~arp_pkg::MOV_OPC_MASK;
            if (!d[63]) begin
                res = res | arp_pkg::MOV_OPC_MOVZ;
            end else begin
                imm = ~imm;
            end
        end
        res[20:5] = imm[15:0];
        ovf = imm > 64'h0000_0000_0000_ffff;
        return res;
    endfunction

    function automatic patch_t patch_reloc(input reloc_t r);
        logic [63:0] sa;
        logic [63:0] d;
        logic [63:0] nw;
        logic [31:0] insn;
        logic [1:0]  wsize;
        logic [1:0]  st;
        logic        chk;
        logic        ovf;
        int unsigned lsb;
        patch_t      p;
        sa    = r.symbol_value + r.addend;
        insn  = r.old_word[31:0];
        nw    = r.old_word;
        wsize = arp_pkg::SIZE_32;
        st    = arp_pkg::ST_OK;
        chk   = 1'b1;
        ovf   = 1'b0;
        case (r.action)
            arp_pkg::R_NONE: wsize = arp_pkg::SIZE_NONE;
            arp_pkg::R_ABS64, arp_pkg::R_PREL64: begin
                nw    = reloc_value(r.action == arp_pkg::R_ABS64 ? arp_pkg::KIND_ABS
                                                                 : arp_pkg::KIND_PREL,
                                    r.place_address, sa);
                wsize = arp_pkg::SIZE_64;
                chk   = 1'b0;
            end
            arp_pkg::R_ABS32, arp_pkg::R_PREL32: begin
                d = reloc_value(r.action == arp_pkg::R_ABS32 ? arp_pkg::KIND_ABS
                                                             : arp_pkg::KIND_PREL,
                                r.place_address, sa);
                if (r.action == arp_pkg::R_ABS32) begin
                    ovf = $signed(d) < 64'sd0 || $signed(d) > 64'sh0000_0000_ffff_ffff;
                end else begin
                    ovf = $signed(d) < 64'shffff_ffff_8000_0000 ||
                          $signed(d) > 64'sh0000_0000_7fff_ffff;
                end
                nw = {r.old_word[63:32], d[31:0]};
            end
            arp_pkg::R_ABS16, arp_pkg::R_PREL16: begin
                d = reloc_value(r.action == arp_pkg::R_ABS16 ? arp_pkg::KIND_ABS
                                                             : arp_pkg::KIND_PREL,
                                r.place_address, sa);
                if (r.action == arp_pkg::R_ABS16) begin
                    ovf = $signed(d) < 64'sd0 || $signed(d) > 64'sh0000_0000_0000_ffff;
                end else begin
                    ovf = $signed(d) < 64'shffff_ffff_ffff_8000 ||
                          $signed(d) > 64'sh0000_0000_0000_7fff;
                end
                nw    = {r.old_word[63:16], d[15:0]};
                wsize = arp_pkg::SIZE_16;
            end
            arp_pkg::R_MOVW_UABS_G0, arp_pkg::R_MOVW_UABS_G0_NC,
            arp_pkg::R_MOVW_UABS_G1, arp_pkg::R_MOVW_UABS_G1_NC,
            arp_pkg::R_MOVW_UABS_G2, arp_pkg::R_MOVW_UABS_G2_NC,
            arp_pkg::R_MOVW_UABS_G3: begin
                chk  = r.action == arp_pkg::R_MOVW_UABS_G0 ||
                       r.action == arp_pkg::R_MOVW_UABS_G1 ||
                       r.action == arp_pkg::R_MOVW_UABS_G2;
                lsb  = ((r.action - arp_pkg::R_MOVW_UABS_G0) >> 1) * 16;
                insn = insert_movw(sa, lsb, 1'b0, insn, ovf);
            end
            arp_pkg::R_MOVW_SABS_G0, arp_pkg::R_MOVW_SABS_G1, arp_pkg::R_MOVW_SABS_G2: begin
                lsb  = (r.action - arp_pkg::R_MOVW_SABS_G0) * 16;
                insn = insert_movw(sa, lsb, 1'b1, insn, ovf);
            end
            arp_pkg::R_MOVW_PREL_G0, arp_pkg::R_MOVW_PREL_G0_NC,
            arp_pkg::R_MOVW_PREL_G1, arp_pkg::R_MOVW_PREL_G1_NC,
            arp_pkg::R_MOVW_PREL_G2, arp_pkg::R_MOVW_PREL_G2_NC,
            arp_pkg::R_MOVW_PREL_G3: begin
                d    = reloc_value(arp_pkg::KIND_PREL, r.place_address, sa);
                chk  = r.action == arp_pkg::R_MOVW_PREL_G0 ||
                       r.action == arp_pkg::R_MOVW_PREL_G1 ||
                       r.action == arp_pkg::R_MOVW_PREL_G2;
                lsb  = ((r.action - arp_pkg::R_MOVW_PREL_G0) >> 1) * 16;
                // checked groups and g3 use the signed movz/movn form
                insn = insert_movw(d, lsb, r.action[0], insn, ovf);
            end
            arp_pkg::R_LD_PREL_LO19, arp_pkg::R_CONDBR19:
                insn = insert_imm(reloc_value(arp_pkg::KIND_PREL, r.place_address, sa),
                                  2, 19, FLD_IMM19, insn, ovf);
            arp_pkg::R_ADR_PREL_LO21:
                insn = insert_imm(reloc_value(arp_pkg::KIND_PREL, r.place_address, sa),
                                  0, 21, FLD_ADR, insn, ovf);
            arp_pkg::R_ADR_PREL_PG_HI21, arp_pkg::R_ADR_PG_HI21_NC: begin
                chk  = r.action == arp_pkg::R_ADR_PREL_PG_HI21;
                insn = insert_imm(reloc_value(arp_pkg::KIND_PAGE, r.place_address, sa),
                                  12, 21, FLD_ADR, insn, ovf);
            end
            arp_pkg::R_ADD_ABS_LO12_NC, arp_pkg::R_LDST8_LO12_NC: begin
                chk  = 1'b0;
                insn = insert_imm(sa, 0, 12, FLD_IMM12, insn, ovf);
            end
            arp_pkg::R_LDST16_LO12_NC, arp_pkg::R_LDST32_LO12_NC,
            arp_pkg::R_LDST64_LO12_NC: begin
                chk  = 1'b0;
                lsb  = r.action - arp_pkg::R_CALL26;
                insn = insert_imm(sa, lsb, 12 - lsb, FLD_IMM12, insn, ovf);
            end
            arp_pkg::R_LDST128_LO12_NC: begin
                chk  = 1'b0;
                insn = insert_imm(sa, 4, 8, FLD_IMM12, insn, ovf);
            end
            arp_pkg::R_TSTBR14:
                insn = insert_imm(reloc_value(arp_pkg::KIND_PREL, r.place_address, sa),
                                  2, 14, FLD_IMM14, insn, ovf);
            arp_pkg::R_JUMP26, arp_pkg::R_CALL26:
                insn = insert_imm(reloc_value(arp_pkg::KIND_PREL, r.place_address, sa),
                                  2, 26, FLD_IMM26, insn, ovf);
            default: begin
                wsize = arp_pkg::SIZE_NONE;
                st    = arp_pkg::ST_UNSUP;
            end
        endcase
        // instruction types write back the patched low word
        if (st == arp_pkg::ST_OK && wsize == arp_pkg::SIZE_32 &&
            r.action != arp_pkg::R_ABS32 && r.action != arp_pkg::R_PREL32) begin
            nw = {r.old_word[63:32], insn};
        end
        if (st == arp_pkg::ST_OK && chk && ovf) begin
            st = arp_pkg::ST_OVF;
        end
        p.new_word   = nw;
        p.write_size = wsize;
        p.status     = st;
        return p;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_reloc(input logic [31:0] action, input logic [63:0] place,
                               input logic [63:0] sym, input logic [63:0] addend,
                               input logic [63:0] old_word);
        reloc_t r;
        r.action        = action;
        r.place_address = place;
        r.symbol_value  = sym;
        r.addend        = addend;
        r.old_word      = old_word;
        pending_relocs.push_back(r);
        relocs_queued++;
    endtask

    // value of random bit length and sign, often right on a power of two
    function automatic logic [63:0] rand_span();
        int unsigned k;
        logic [63:0] v;
        k = $urandom_range(64);
        if ($urandom_range(1)) begin
            v = {$urandom, $urandom};
            if (k < 64) begin
                v &= (64'd1 << k) - 64'd1;
            end
        end else begin
            v = (64'd1 << k) + 64'($urandom_range(2)) - 64'd1;
        end
        if ($urandom_range(1)) begin
            v = -v;
        end
        return v;
    endfunction

    // mostly supported types with s+a near the place or near zero, so the
    // range checks land on both sides; some null and unknown types
    task automatic queue_random_reloc();
        logic [31:0] action;
        logic [63:0] place;
        logic [63:0] addend;
        logic [63:0] sa;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 85) begin
            action = known_types[$urandom_range(36)];
        end else if (pick < 90) begin
            action = arp_pkg::R_NONE;
        end else begin
            action = $urandom;
        end
        place  = {$urandom, $urandom};
        addend = $urandom_range(1) ? {$urandom, $urandom} : rand_span();
        case ($urandom_range(3))
            0, 1:    sa = place + rand_span();
            2:       sa = rand_span();
            default: sa = {$urandom, $urandom};
        endcase
        queue_reloc(action, place, sa - addend, addend, {$urandom, $urandom});
    endtask

    // ---------------------------------------------------------------
    // driver: offers queued relocations on s_, with random idle cycles
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // transaction taken at this edge: predict its result
            if (s_tvalid && s_tready) begin
                expected_patches.push_back(patch_reloc(offered_reloc));
                relocs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_relocs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_reloc = pending_relocs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_reloc.old_word, offered_reloc.addend,
                                 offered_reloc.symbol_value, offered_reloc.place_address,
                                 offered_reloc.action};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random backpressure on m_, checks each result in order
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        patch_t want;
        patch_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.new_word   = m_tdata[63:0];
                got.write_size = m_tdata[65:64];
                got.status     = m_tdata[67:66];
                if (expected_patches.size() == 0) begin
                    $display("%0t: unexpected result new_word=%h write_size=%0d status=%0d",
                             $time, got.new_word, got.write_size, got.status);
                    mismatches++;
                end else begin
                    want = expected_patches.pop_front();
                    if (got.new_word !== want.new_word) begin
                        $display("%0t: new_word expected %h actual %h",
                                 $time, want.new_word, got.new_word);
                        mismatches++;
                    end
                    if (got.write_size !== want.write_size) begin
                        $display("%0t: write_size expected %0d actual %0d",
                                 $time, want.write_size, got.write_size);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long without a transaction on either side
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence: reset, directed relocations, then random phases
    // ---------------------------------------------------------------
    initial begin : sequencer
        int unsigned idle_pcts  [0:3];
        int unsigned stall_pcts [0:3];
        logic [63:0] place;
        logic [63:0] old_w;
        idle_pcts  = '{0, 80, 0, 24};
        stall_pcts = '{0, 0, 80, 24};
        place = 64'h0000_0040_1234_5678;
        old_w = 64'hcafe_f00d_9400_0000;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // null and unknown types
        queue_reloc(arp_pkg::R_NONE, '1, '1, '1, '1);
        queue_reloc(32'd256, place, 64'h1000, 64'd0, old_w);
        queue_reloc(32'hffff_ffff, '1, '0, '1, '1);
        queue_reloc(32'd281, place, 64'h1000, 64'd0, old_w);
        // data relocations around their range limits
        queue_reloc(arp_pkg::R_ABS64, 64'd0, '1, 64'd1, '1);
        queue_reloc(arp_pkg::R_PREL64, place, 64'd0, 64'd0, old_w);
        queue_reloc(arp_pkg::R_ABS32, place, 64'h0000_0000_ffff_ffff, 64'd0, '0);
        queue_reloc(arp_pkg::R_ABS32, place, 64'h0000_0001_0000_0000, 64'd0, '1);
        queue_reloc(arp_pkg::R_ABS32, place, 64'd0, '1, old_w);
        queue_reloc(arp_pkg::R_ABS16, place, 64'hffff, 64'd0, '1);
        queue_reloc(arp_pkg::R_ABS16, place, 64'hffff, 64'd1, '1);
        queue_reloc(arp_pkg::R_PREL16, place, place - 64'd32768, 64'd0, old_w);
        queue_reloc(arp_pkg::R_PREL16, place, place + 64'd32768, 64'd0, old_w);
        queue_reloc(arp_pkg::R_PREL32, place, place, -64'sd2147483649, old_w);
        // move-wide groups: overflow, g3, movn on a negative value
        queue_reloc(arp_pkg::R_MOVW_UABS_G0, place, 64'h1_0000, 64'd0,
                    64'h0000_0000_f280_0000);
        queue_reloc(arp_pkg::R_MOVW_UABS_G3, place, '1, 64'd0, 64'h0000_0000_f2e0_0000);
        queue_reloc(arp_pkg::R_MOVW_SABS_G0, place, '1, 64'd0, 64'h0000_0000_f280_0000);
        queue_reloc(arp_pkg::R_MOVW_SABS_G2, place, 64'h0001_0000_0000_0000, 64'd0, '1);
        queue_reloc(arp_pkg::R_MOVW_PREL_G3, place, 64'd0, 64'd0, old_w);
        // immediate fields at and past their reach
        queue_reloc(arp_pkg::R_LD_PREL_LO19, place, place + 64'h10_0000, 64'd0,
                    64'h0000_0000_5800_0000);
        queue_reloc(arp_pkg::R_ADR_PREL_LO21, place, place - 64'h10_0000, 64'd0,
                    64'h0000_0000_1000_0000);
        queue_reloc(arp_pkg::R_ADR_PREL_PG_HI21, place, place + 64'h1_0000_0000, 64'd0, '1);
        queue_reloc(arp_pkg::R_ADR_PG_HI21_NC, place, place + 64'h1_0000_0000, 64'd0, '1);
        queue_reloc(arp_pkg::R_CALL26, place, place + 64'h800_0000, 64'd0, old_w);
        queue_reloc(arp_pkg::R_TSTBR14, place, place - 64'h8000, 64'd0,
                    64'h0000_0000_3600_0000);

        for (int ph = 0; ph < 4; ph++) begin
            @(negedge aclk);
            send_idle_pct  = idle_pcts[ph];
            recv_stall_pct = stall_pcts[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                queue_random_reloc();
            end
            while (relocs_taken != relocs_queued) @(negedge aclk);
        end

        while (expected_patches.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/arp_pkg.sv
rtl/arp_decode.sv
rtl/arp_patch.sv
rtl/aarch64_relocation_patcher_core.sv
rtl/arp_checker.sv
test/tb_aarch64_relocation_patcher_core.sv
